// ----- hdl/sorted_priority_queue_assert.svh -----
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, disabled while reset is held
`define SPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked check that also holds during reset
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SPQ_ASSERT(label, clk, rst_n, prop, msg)
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- hdl/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
package spq_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int DATA_W_DEF = 16;
    localparam int PRIO_W_DEF = 16;
    localparam int COUNT_OUT_W = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-beat command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

endpackage

// ----- hdl/spq_cell.sv -----
// one slot of the sorted store: holds an entry and trades it with its neighbors
module spq_cell #(
    parameter int DATA_WIDTH = spq_pkg::DATA_W_DEF,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_W_DEF
) (
    input  logic                  i_clk,
    input  spq_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_occupied,
    input  logic [DATA_WIDTH-1:0] i_new_data,
    input  logic [PRIO_WIDTH-1:0] i_new_prio,
    input  logic                  i_left_before,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic [PRIO_WIDTH-1:0] i_left_prio,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic [PRIO_WIDTH-1:0] i_right_prio,
    output logic                  o_before,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [PRIO_WIDTH-1:0] o_prio
);
    import spq_pkg::*;

    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic [PRIO_WIDTH-1:0] r_prio, n_prio;

    // new entry lands at or ahead of this slot
    assign o_before = !i_occupied || (i_new_prio <= r_prio);

    always_comb begin
        n_data = r_data;
        n_prio = r_prio;
        if (i_ctl.pop) begin
            n_data = i_right_data;
            n_prio = i_right_prio;
        end else if (i_ctl.ins) begin
            if (i_left_before) begin
                n_data = i_left_data;
                n_prio = i_left_prio;
            end else if (o_before) begin
                n_data = i_new_data;
                n_prio = i_new_prio;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
    end

    assign o_data = r_data;
    assign o_prio = r_prio;

endmodule

// ----- hdl/sorted_priority_queue.sv -----
// top level of the sorted priority queue: cell row, count and result register
//
// Min-priority queue of up to DEPTH entries kept sorted in a row of cells, smallest
// priority at the head; an insert goes ahead of all stored entries of equal or larger
// priority, so ties leave newest first. One beat is accepted every clock cycle unless
// o_in_stall is high: every cell compares its priority with the incoming one in parallel
// and takes its own, its left neighbor's, its right neighbor's or the new entry in that
// same cycle. The result beat appears in the output register in the cycle after
// acceptance; the next command may be accepted while it waits unless output is stalled.
// An insert into a full queue is dropped with status 1, a pop on an empty queue
// reports status 2; data and priority outputs are zero on every beat but a good pop.
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = spq_pkg::DATA_W_DEF,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_W_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_cmd,
    input  logic [DATA_WIDTH-1:0]           i_data_in,
    input  logic [PRIO_WIDTH-1:0]           i_priority_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [DATA_WIDTH-1:0]           o_data_out,
    output logic [PRIO_WIDTH-1:0]           o_priority_out,
    output logic [1:0]                      o_status,
    output logic [spq_pkg::COUNT_OUT_W-1:0] o_count_out
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    logic [DATA_WIDTH-1:0]  r_data_out, n_data_out;
    logic [PRIO_WIDTH-1:0]  r_prio_out, n_prio_out;
    t_status                r_status, n_status;
    logic [COUNT_OUT_W-1:0] r_count_out, n_count_out;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_cell_ctl w_ctl;

    logic [DEPTH-1:0]      w_occ;
    logic [DEPTH-1:0]      w_before;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [PRIO_WIDTH-1:0] w_prio [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    assign w_ctl.ins = w_accept && (i_cmd == CMD_INSERT) && !w_full;
    assign w_ctl.pop = w_accept && (i_cmd == CMD_POP) && !w_empty;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                  w_left_before;
        logic [DATA_WIDTH-1:0] w_left_data, w_right_data;
        logic [PRIO_WIDTH-1:0] w_left_prio, w_right_prio;

        assign w_occ[i] = (r_count > CNT_W'(i));

        if (i == 0) begin : g_head
            assign w_left_before = 1'b0;
            assign w_left_data   = i_data_in;
            assign w_left_prio   = i_priority_in;
        end else begin : g_mid
            assign w_left_before = w_before[i-1];
            assign w_left_data   = w_data[i-1];
            assign w_left_prio   = w_prio[i-1];
        end

        // the tail slot refills with its own content on a pop, never read afterward
        if (i == DEPTH - 1) begin : g_tail
            assign w_right_data = w_data[i];
            assign w_right_prio = w_prio[i];
        end else begin : g_body
            assign w_right_data = w_data[i+1];
            assign w_right_prio = w_prio[i+1];
        end

        spq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .PRIO_WIDTH (PRIO_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_occupied    (w_occ[i]),
            .i_new_data    (i_data_in),
            .i_new_prio    (i_priority_in),
            .i_left_before (w_left_before),
            .i_left_data   (w_left_data),
            .i_left_prio   (w_left_prio),
            .i_right_data  (w_right_data),
            .i_right_prio  (w_right_prio),
            .o_before      (w_before[i]),
            .o_data        (w_data[i]),
            .o_prio        (w_prio[i])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_data_out  = r_data_out;
        n_prio_out  = r_prio_out;
        n_status    = r_status;
        n_count_out = r_count_out;
        if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_data_out  = '0;
            n_prio_out  = '0;
            n_status    = ST_OK;
            n_count_out = COUNT_OUT_W'(n_count);
            if (i_cmd == CMD_INSERT) begin
                if (w_full) begin
                    n_status = ST_FULL;
                end
            end else begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_data_out = w_data[0];
                    n_prio_out = w_prio[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_data_out  <= n_data_out;
        r_prio_out  <= n_prio_out;
        r_status    <= n_status;
        r_count_out <= n_count_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_out     = r_data_out;
    assign o_priority_out = r_prio_out;
    assign o_status       = r_status;
    assign o_count_out    = r_count_out;

    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "count above depth")
    `SPQ_ASSERT(a_full_drop, i_clk, i_rst_n, (w_accept && i_cmd == CMD_INSERT && w_full) |=> (r_status == ST_FULL && r_count == $past(r_count)), "full insert not dropped")
    `SPQ_ASSERT(a_empty_pop, i_clk, i_rst_n, (w_accept && i_cmd == CMD_POP && w_empty) |=> (r_status == ST_EMPTY && r_data_out == '0 && r_count == '0), "empty pop misreported")
    `SPQ_ASSERT(a_head_sorted, i_clk, i_rst_n, (r_count >= CNT_W'(2)) |-> (w_prio[0] <= w_prio[1]), "head out of order")
    `SPQ_ASSERT_ALWAYS(a_reset_idle, i_clk, !$past(i_rst_n) |-> (!r_out_valid && r_count == '0), "state not cleared by reset")

endmodule
